// ----- rtl/core/sha1c_pkg.sv -----
package sha1c_pkg;

  typedef logic [31:0] word_t;
  typedef logic [6:0]  rnd_t;

  localparam int unsigned ROUNDS     = 80;
  localparam int unsigned SCHED_LEN  = 16;
  localparam int unsigned CK_W       = 7;
  localparam int unsigned CK_SHIFT   = 25;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned CODE_W     = ID_W + CK_W;

  localparam rnd_t  LAST_RND  = rnd_t'(ROUNDS - 1);

  // Padding words of the single message block.
  localparam word_t PAD_WORD  = 32'h8000_0000;
  localparam word_t MSG_BITS  = 32'd32;

  // Initial chaining values.
  localparam word_t H0_INIT   = 32'h6745_2301;
  localparam word_t H1_INIT   = 32'hEFCD_AB89;
  localparam word_t H2_INIT   = 32'h98BA_DCFE;
  localparam word_t H3_INIT   = 32'h1032_5476;
  localparam word_t H4_INIT   = 32'hC3D2_E1F0;

  // Control passed from the sequencer to the datapath parts.
  typedef struct packed {
    logic load;   // start a new block
    logic step;   // run one round
    rnd_t rnd;    // index of the round being run
  } ctrl_t;

endpackage

// ----- rtl/core/sha1c_sched.sv -----
module sha1c_sched
  import sha1c_pkg::*;
(
  input  logic  clk_i,
  input  ctrl_t ctrl_i,
  input  word_t account_id_i,
  output word_t w_o
);

  // Window of sixteen schedule words; entry 0 is the word of the current round.
  word_t win_q [SCHED_LEN];
  word_t win_d [SCHED_LEN];
  word_t mix;

  assign mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];

  always_comb begin
    for (int i = 0; i < SCHED_LEN; i++) begin
      win_d[i] = win_q[i];
    end
    if (ctrl_i.load) begin
      // Bytes go in least significant first, packed big-endian.
      win_d[0] = {account_id_i[7:0], account_id_i[15:8],
                  account_id_i[23:16], account_id_i[31:24]};
      win_d[1] = PAD_WORD;
      for (int i = 2; i < SCHED_LEN - 1; i++) begin
        win_d[i] = '0;
      end
      win_d[SCHED_LEN-1] = MSG_BITS;
    end else if (ctrl_i.step) begin
      for (int i = 0; i < SCHED_LEN - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[SCHED_LEN-1] = {mix[30:0], mix[31]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SCHED_LEN; i++) begin
      win_q[i] <= win_d[i];
    end
  end

  assign w_o = win_q[0];

endmodule

// ----- rtl/core/sha1c_round.sv -----
module sha1c_round
  import sha1c_pkg::*;
(
  input  logic  clk_i,
  input  ctrl_t ctrl_i,
  input  word_t w_i,
  output word_t h0_o
);

  word_t a_q, b_q, c_q, d_q, e_q;
  word_t a_d, b_d, c_d, d_d, e_d;
  word_t f, k, t;

  // Round function and constant per group of twenty rounds.
  always_comb begin
    if (ctrl_i.rnd < rnd_t'(20)) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5A82_7999;
    end else if (ctrl_i.rnd < rnd_t'(40)) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ED9_EBA1;
    end else if (ctrl_i.rnd < rnd_t'(60)) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8F1B_BCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hCA62_C1D6;
    end
  end

  assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_i;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    if (ctrl_i.load) begin
      a_d = H0_INIT;
      b_d = H1_INIT;
      c_d = H2_INIT;
      d_d = H3_INIT;
      e_d = H4_INIT;
    end else if (ctrl_i.step) begin
      a_d = t;
      b_d = a_q;
      c_d = {b_q[1:0], b_q[31:2]};
      d_d = c_q;
      e_d = d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    e_q <= e_d;
  end

  // Only the first digest word is needed.
  assign h0_o = a_q + H0_INIT;

endmodule

// ----- rtl/core/id_checksum_sha1_core.sv -----
// Computes a 7-bit SHA-1 check value for a 32-bit account identifier. The
// identifier is hashed as a four-byte message, least significant byte first,
// padded to a single 512-bit block, and the check bits are the top seven bits
// of the first digest word. Each request returns check_bits_o and
// combined_code_o, which carries the identifier in bits 31:0 and the check
// bits in bits 38:32. One compression round runs per clock on a shared round
// unit, fed by a sixteen-word schedule window: the accepting edge loads the
// block, the rounds follow one per cycle, and the final state adds the first
// digest word into the result register. The input stalls while a request is
// being hashed and opens again in the cycle after the result is loaded, so a
// new request is not taken before the previous one is through. A finished
// result sits in an output register, so a new request is taken as soon as
// the hash is done even if the previous result has not been collected; if
// the output register is still full when the next hash completes, the core
// waits until it frees up.
module id_checksum_sha1_core
  import sha1c_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ID_W-1:0]     account_id_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CK_W-1:0]     check_bits_o,
  output logic [CODE_W-1:0]   combined_code_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e          state_q, state_d;
  rnd_t            rnd_q, rnd_d;
  logic            out_valid_q, out_valid_d;
  logic [ID_W-1:0] id_q;
  logic [CK_W-1:0] ck_q;
  logic            in_acc;
  logic            out_free;
  logic            res_load;
  ctrl_t           ctrl;
  word_t           w;
  word_t           h0;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign res_load = (state_q == ST_FIN) && out_free;

  assign ctrl.load = in_acc;
  assign ctrl.step = (state_q == ST_RUN);
  assign ctrl.rnd  = rnd_q;

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          rnd_d   = '0;
        end
      end
      ST_RUN: begin
        rnd_d = rnd_q + rnd_t'(1);
        if (rnd_q == LAST_RND) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait here while the previous result is still held downstream.
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The identifier is kept for the combined code while the hash runs.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q <= account_id_i;
    end
    if (res_load) begin
      ck_q <= h0[31:CK_SHIFT];
    end
  end

  logic [ID_W-1:0] out_id_q;

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_id_q <= id_q;
    end
  end

  sha1c_sched u_sched (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .account_id_i (account_id_i),
    .w_o          (w)
  );

  sha1c_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .w_i    (w),
    .h0_o   (h0)
  );

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign check_bits_o    = ck_q;
  assign combined_code_o = {ck_q, out_id_q};

  // An accepted request always starts at the first round.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_RUN && rnd_q == '0)
    else $error("request accepted without starting at round zero");

  // The round counter never runs past the last round.
  a_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> rnd_q <= LAST_RND)
    else $error("round counter out of range");

  // A result only appears after a completed hash.
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("result raised without a finished hash");

  // The core waits in the final state only while the output is held.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && out_valid_q && out_stall_i |=> state_q == ST_FIN)
    else $error("result dropped while output held");

endmodule
